@@ rtl/perceptual_brightness_stepper_core_assert.svh @@
// Assertion macros shared by the brightness stepper RTL modules.
// Depends on nothing; each macro expects i_clk and i_rst_n in scope.
`ifndef PERCEPTUAL_BRIGHTNESS_STEPPER_CORE_ASSERT_SVH
`define PERCEPTUAL_BRIGHTNESS_STEPPER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PBS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pbs assertion failed");

// Next-cycle implication, checked outside reset.
`define PBS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pbs assertion failed");

`endif

@@ rtl/pbs_pkg.sv @@
// Package of the brightness stepper: widths, curve factor table, microcode types and program.
// Depends on nothing; used by pbs_seq, pbs_datapath and the top level.
`default_nettype none

package pbs_pkg;

    localparam int TableLen = 11;
    localparam int AddrW    = (TableLen > 1) ? $clog2(TableLen) : 1;
    localparam int LevelW   = 24;
    localparam int StepInW  = 8;
    localparam int IdxW     = 6;
    localparam int FactorW  = 25;
    localparam int ProdW    = FactorW + LevelW;
    localparam int SumW     = 10;
    localparam int DataW    = 32;
    localparam int StepW    = 3;
    localparam int ProgLen  = 6;

    localparam logic [127:0] Span     = 128'(TableLen - 1);
    localparam logic [127:0] DenLin2  = 128'(2) * 128'(9023) * Span;
    localparam logic [127:0] DenCubB  = 128'(116) * Span;
    localparam logic [127:0] DenCub2  = 128'(2) * DenCubB * DenCubB * DenCubB;
    localparam logic [127:0] Q24One   = 128'(1) << 24;
    localparam logic [ProdW-1:0] RoundHalf = ProdW'(1) << 23;

    typedef logic [FactorW-1:0] t_factor_tab [TableLen];

    function automatic logic [FactorW-1:0] curve_factor(int unsigned i);
        logic [127:0] a;
        logic [127:0] num;
        logic [127:0] res;
        if (128'(100) * 128'(i) < 128'(9) * Span) begin
            num = 128'(1000) * 128'(i) * Q24One;
            res = (128'(2) * num + DenLin2 / 128'(2)) / DenLin2;
        end else begin
            a   = 128'(100) * 128'(i) + 128'(16) * Span;
            num = a * a * a * Q24One;
            res = (128'(2) * num + DenCub2 / 128'(2)) / DenCub2;
        end
        return res[FactorW-1:0];
    endfunction

    function automatic t_factor_tab build_table();
        t_factor_tab tab;
        for (int unsigned k = 0; k < TableLen; k++) begin
            tab[k] = curve_factor(k);
        end
        return tab;
    endfunction

    localparam t_factor_tab CurveTable = build_table();

    typedef logic [StepW-1:0] t_pc;

    typedef enum logic [2:0] {
        OP_WAIT,
        OP_MUL,
        OP_SCAN,
        OP_TARGET,
        OP_EMIT
    } t_op;

    typedef enum logic [2:0] {
        C_NEXT,
        C_GOTO,
        C_MORE,
        C_WAIT_IN,
        C_WAIT_OUT
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   target;
    } t_ctrl;

    typedef struct packed {
        logic in_fire;
        logic scan_more;
        logic out_free;
    } t_status;

    localparam t_pc PcIdle    = t_pc'(0);
    localparam t_pc PcScanMul = t_pc'(1);

    typedef t_ctrl t_prog [ProgLen];

    localparam t_prog Microcode = '{
        '{OP_WAIT,   C_WAIT_IN,  PcIdle},
        '{OP_MUL,    C_NEXT,     PcIdle},
        '{OP_SCAN,   C_MORE,     PcScanMul},
        '{OP_TARGET, C_NEXT,     PcIdle},
        '{OP_MUL,    C_NEXT,     PcIdle},
        '{OP_EMIT,   C_WAIT_OUT, PcIdle}
    };

endpackage

`default_nettype wire

@@ rtl/pbs_seq.sv @@
// Microcode sequencer: step counter, program table read and conditional jumps.
// Depends on pbs_pkg and the assertion macro header.
`default_nettype none
`include "perceptual_brightness_stepper_core_assert.svh"

module pbs_seq (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire pbs_pkg::t_status i_status,
    output pbs_pkg::t_ctrl        o_ctrl
);

    pbs_pkg::t_pc   r_pc;
    pbs_pkg::t_pc   n_pc;
    pbs_pkg::t_ctrl w_ctrl;

    always_comb begin
        if (r_pc <= pbs_pkg::t_pc'(pbs_pkg::ProgLen - 1)) begin
            w_ctrl = pbs_pkg::Microcode[r_pc];
        end else begin
            w_ctrl = pbs_pkg::Microcode[pbs_pkg::PcIdle];
        end
    end

    always_comb begin
        unique case (w_ctrl.cond)
            pbs_pkg::C_NEXT:     n_pc = r_pc + pbs_pkg::t_pc'(1);
            pbs_pkg::C_GOTO:     n_pc = w_ctrl.target;
            pbs_pkg::C_MORE:     n_pc = i_status.scan_more ? w_ctrl.target
                                                           : r_pc + pbs_pkg::t_pc'(1);
            pbs_pkg::C_WAIT_IN:  n_pc = i_status.in_fire ? r_pc + pbs_pkg::t_pc'(1) : r_pc;
            pbs_pkg::C_WAIT_OUT: n_pc = i_status.out_free ? w_ctrl.target : r_pc;
            default:             n_pc = pbs_pkg::PcIdle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= pbs_pkg::PcIdle;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctrl = w_ctrl;

    `PBS_ASSERT_IMP(a_pc_range, 1'b1, r_pc <= pbs_pkg::t_pc'(pbs_pkg::ProgLen - 1))
    `PBS_ASSERT_NXT(a_wait_holds, (w_ctrl.cond == pbs_pkg::C_WAIT_IN) && !i_status.in_fire,
        $stable(r_pc))
    `PBS_ASSERT_NXT(a_scan_loops, (w_ctrl.cond == pbs_pkg::C_MORE) && i_status.scan_more,
        r_pc == pbs_pkg::PcScanMul)

endmodule

`default_nettype wire

@@ rtl/pbs_datapath.sv @@
// Datapath of the brightness stepper: curve multiply, nearest-level scan, clamp and output register.
// Depends on pbs_pkg and the assertion macro header; driven by pbs_seq.
`default_nettype none
`include "perceptual_brightness_stepper_core_assert.svh"

module pbs_datapath (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire pbs_pkg::t_ctrl              i_ctrl,
    input  wire logic                        i_cfg_valid,
    input  wire logic [pbs_pkg::LevelW-1:0]  i_cfg_data,
    input  wire logic                        i_in_valid,
    input  wire logic [pbs_pkg::DataW-1:0]   i_in_data,
    input  wire logic                        i_out_ready,
    output logic                             o_out_valid,
    output logic [pbs_pkg::DataW-1:0]        o_out_data,
    output pbs_pkg::t_status                 o_status
);

    localparam logic [pbs_pkg::AddrW-1:0] Last = pbs_pkg::AddrW'(pbs_pkg::TableLen - 1);

    logic [pbs_pkg::LevelW-1:0]         r_max;
    logic [pbs_pkg::LevelW-1:0]         r_cur;
    logic signed [pbs_pkg::StepInW-1:0] r_step;
    logic [pbs_pkg::AddrW-1:0]          r_addr;
    logic [pbs_pkg::AddrW-1:0]          r_idx;
    logic [pbs_pkg::LevelW-1:0]         r_diff;
    logic                               r_first;
    logic [pbs_pkg::ProdW-1:0]          r_prod;
    logic                               r_out_valid;
    logic [pbs_pkg::LevelW-1:0]         r_out_level;
    logic [pbs_pkg::IdxW-1:0]           r_out_index;

    logic                               w_in_fire;
    logic                               w_out_free;
    logic [pbs_pkg::FactorW-1:0]        w_factor;
    logic [pbs_pkg::LevelW:0]           w_raw;
    logic [pbs_pkg::LevelW-1:0]         w_level;
    logic [pbs_pkg::LevelW-1:0]         w_dist;
    logic                               w_better;
    logic                               w_more;
    logic signed [pbs_pkg::SumW-1:0]    w_sum;
    logic [pbs_pkg::AddrW-1:0]          w_target;

    assign w_in_fire  = i_in_valid && (i_ctrl.op == pbs_pkg::OP_WAIT);
    assign w_out_free = !r_out_valid || i_out_ready;

    assign w_factor = pbs_pkg::CurveTable[r_addr];
    assign w_raw    = r_prod[pbs_pkg::ProdW-1:24];
    assign w_level  = (w_raw > {1'b0, r_max}) ? r_max : w_raw[pbs_pkg::LevelW-1:0];
    assign w_dist   = (r_cur >= w_level) ? (r_cur - w_level) : (w_level - r_cur);
    assign w_better = r_first || (r_diff > w_dist);
    assign w_more   = w_better && (r_addr != Last);

    assign w_sum = $signed({{(pbs_pkg::SumW - pbs_pkg::AddrW){1'b0}}, r_idx})
                 + $signed({{(pbs_pkg::SumW - pbs_pkg::StepInW){r_step[pbs_pkg::StepInW-1]}},
                            r_step});

    always_comb begin
        priority if (w_sum[pbs_pkg::SumW-1]) begin
            w_target = '0;
        end else if (w_sum > $signed(pbs_pkg::SumW'(pbs_pkg::TableLen - 1))) begin
            w_target = Last;
        end else begin
            w_target = w_sum[pbs_pkg::AddrW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max       <= '0;
            r_addr      <= '0;
            r_idx       <= '0;
            r_first     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_max <= i_cfg_data;
            end
            if ((i_ctrl.op == pbs_pkg::OP_EMIT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (i_ctrl.op)
                pbs_pkg::OP_WAIT: begin
                    if (w_in_fire) begin
                        r_cur   <= i_in_data[pbs_pkg::LevelW-1:0];
                        r_step  <= i_in_data[pbs_pkg::LevelW +: pbs_pkg::StepInW];
                        r_addr  <= '0;
                        r_idx   <= '0;
                        r_first <= 1'b1;
                    end
                end
                pbs_pkg::OP_MUL: begin
                    r_prod <= {{pbs_pkg::LevelW{1'b0}}, w_factor}
                            * {{pbs_pkg::FactorW{1'b0}}, r_max} + pbs_pkg::RoundHalf;
                end
                pbs_pkg::OP_SCAN: begin
                    if (w_better) begin
                        r_idx   <= r_addr;
                        r_diff  <= w_dist;
                        r_first <= 1'b0;
                    end
                    if (w_more) begin
                        r_addr <= r_addr + pbs_pkg::AddrW'(1);
                    end
                end
                pbs_pkg::OP_TARGET: begin
                    r_addr <= w_target;
                end
                pbs_pkg::OP_EMIT: begin
                    if (w_out_free) begin
                        r_out_level <= w_level;
                        r_out_index <= pbs_pkg::IdxW'(r_addr);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_out_data         = {{(pbs_pkg::DataW - pbs_pkg::LevelW - pbs_pkg::IdxW){1'b0}},
                                 r_out_index, r_out_level};
    assign o_status.in_fire   = w_in_fire;
    assign o_status.scan_more = w_more;
    assign o_status.out_free  = w_out_free;

    `PBS_ASSERT_IMP(a_addr_range, 1'b1, r_addr <= Last)
    `PBS_ASSERT_IMP(a_idx_range, 1'b1, r_idx <= Last)
    `PBS_ASSERT_IMP(a_out_index_range, r_out_valid,
        r_out_index <= pbs_pkg::IdxW'(pbs_pkg::TableLen - 1))

endmodule

`default_nettype wire

@@ rtl/perceptual_brightness_stepper_core.sv @@
// Top level of the perceptual brightness stepper: sequencer and datapath.
// Depends on pbs_pkg, pbs_seq and pbs_datapath.
//
// Use: write max_level on the configuration channel (always ready) while the block is idle.
// Each request on s_axis carries current_level in bits 23:0 and a signed step in bits 31:24.
// The block finds the nearest curve level by scanning from level 0, moves by the step with
// saturation at both ends, and returns the level value in m_axis bits 23:0 and its index in
// bits 29:24. One request gives exactly one result.
// Steps: for each scanned level the sequencer runs a factor multiply, then a compare; after
// the scan it sets the target, multiplies for its level and loads the output register, the
// scan visiting 2 to TableLen levels. From the emit step the program goes back to its
// waiting step, so a new request is taken only after the last one has reached the output
// register. One request is in work at a time; s_axis_tready is high only while the program
// waits for a request.
// Reset clears max_level to zero, empties the output register and returns the program to
// its waiting step. A finished result sits in the output register; a new request is taken
// while it waits, and if the receiver still stalls when the next result is ready, the
// program holds at its emit step until the output register is free.
`default_nettype none

module perceptual_brightness_stepper_core (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [pbs_pkg::LevelW-1:0] i_cfg_data,     // max_level
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire logic [pbs_pkg::DataW-1:0]  s_axis_tdata,   // current_level, step
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    output logic [pbs_pkg::DataW-1:0]       m_axis_tdata    // new_level, level_index, zero pad
);

    pbs_pkg::t_ctrl   w_ctrl;
    pbs_pkg::t_status w_status;

    pbs_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_ctrl   (w_ctrl)
    );

    pbs_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (s_axis_tvalid),
        .i_in_data   (s_axis_tdata),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_status    (w_status)
    );

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (w_ctrl.op == pbs_pkg::OP_WAIT);

endmodule

`default_nettype wire
